@@ src/vertex_transform_4x4_defines.svh @@
// ----------------------------------------------------------------------------
// vertex_transform_4x4 assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VT4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vt4 assertion failed: same-cycle implication");
// next-cycle implication
`define VT4_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vt4 assertion failed: next-cycle implication");
`else
`define VT4_ASSERT_IMP(label, ante, cons)
`define VT4_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ src/vt4_pkg.sv @@
// ----------------------------------------------------------------------------
// vt4_pkg
// Types, widths and constants shared by the vertex transform modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int NUM_REGS  = 8;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;
  localparam int REG_W     = 64;
  localparam int IDX_W     = 4;
  localparam int REG_SEL_W = 3;
  localparam int VEC_W     = NUM_COLS * DATA_W;

  typedef logic signed [DATA_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // func codes
  localparam logic FUNC_AFFINE = 1'b0;
  localparam logic FUNC_FULL   = 1'b1;

  localparam comp_t SAT_MAX = 32'sh7fff_ffff;
  localparam comp_t SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic valid;
    logic func;
    logic last;
  } vt4_ctl_t;

  // identity in Q16.16
  localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

endpackage

`default_nettype wire

@@ src/vt4_lane.sv @@
// ----------------------------------------------------------------------------
// vt4_lane
// One matrix row: four products in the first stage, shifted sum in the second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vt4_lane import vt4_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  comp_t row [NUM_COLS],
  input  comp_t vec [NUM_COLS],
  input  logic  func,
  output sum_t  sum
);

  prod_t prod [NUM_COLS];
  logic  func_q;
  sum_t  sum_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_COLS - 1; c++) begin
        prod[c] <= row[c] * vec[c];
      end
      // affine mode carries the translation entry unscaled in the last slot
      if (func == FUNC_FULL) begin
        prod[NUM_COLS-1] <= row[NUM_COLS-1] * vec[NUM_COLS-1];
      end else begin
        prod[NUM_COLS-1] <= PROD_W'(row[NUM_COLS-1]);
      end
      func_q <= func;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int c = 0; c < NUM_COLS - 1; c++) begin
      sum_next = sum_next + SUM_W'(prod[c] >>> FRAC_BITS);
    end
    if (func_q == FUNC_FULL) begin
      sum_next = sum_next + SUM_W'(prod[NUM_COLS-1] >>> FRAC_BITS);
    end else begin
      sum_next = sum_next + SUM_W'(prod[NUM_COLS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

@@ src/vt4_merge.sv @@
// ----------------------------------------------------------------------------
// vt4_merge
// Saturates the four lane sums, merges the clip flags, holds the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_transform_4x4_defines.svh"

module vt4_merge import vt4_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  sum_t             sums [NUM_ROWS],
  input  vt4_ctl_t         in_ctl,
  output logic             adv,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VEC_W-1:0] m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic             m_axis_tuser,  // clipped
  output logic             m_axis_tlast   // batch_end
);

  comp_t            sat [NUM_ROWS];
  logic [NUM_ROWS-1:0] hit;
  logic [VEC_W-1:0] tdata_next;
  logic             clip_next;

  assign adv = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (sums[r] > SUM_W'(SAT_MAX)) begin
        sat[r] = SAT_MAX;
        hit[r] = 1'b1;
      end else if (sums[r] < SUM_W'(SAT_MIN)) begin
        sat[r] = SAT_MIN;
        hit[r] = 1'b1;
      end else begin
        sat[r] = sums[r][DATA_W-1:0];
        hit[r] = 1'b0;
      end
    end
    // row 3 does not exist in affine mode
    if (in_ctl.func == FUNC_FULL) begin
      clip_next  = |hit;
      tdata_next = {sat[3], sat[2], sat[1], sat[0]};
    end else begin
      clip_next  = |hit[NUM_ROWS-2:0];
      tdata_next = {comp_t'(0), sat[2], sat[1], sat[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= tdata_next;
      m_axis_tuser <= clip_next;
      m_axis_tlast <= in_ctl.last;
    end
  end

  `VT4_ASSERT_NXT(a_affine_w_zero, adv && in_ctl.valid && !in_ctl.func, m_axis_tdata[127:96] == 32'h0)
  `VT4_ASSERT_NXT(a_word_lands, adv && in_ctl.valid, m_axis_tvalid)
  `VT4_ASSERT_IMP(a_clip_at_bound, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[31:0] == SAT_MAX) || (m_axis_tdata[31:0] == SAT_MIN) || (m_axis_tdata[63:32] == SAT_MAX) || (m_axis_tdata[63:32] == SAT_MIN) || (m_axis_tdata[95:64] == SAT_MAX) || (m_axis_tdata[95:64] == SAT_MIN) || (m_axis_tdata[127:96] == SAT_MAX) || (m_axis_tdata[127:96] == SAT_MIN))

endmodule

`default_nettype wire

@@ src/vertex_transform_4x4.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Streaming 4x4 matrix by vector transform in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one vector word per clock and returns one transformed word per clock
// while finished words are taken. A result passes the product, sum and output
// registers before it is valid on the output. Four row lanes of four
// 32x32 multipliers form the products in the first stage, each lane sums its
// shifted products in the second, and the merge stage saturates and drives the
// output register.
// The pipeline stalls as a whole only while a finished word is not taken.
// Matrix registers reset to identity; write them only while the stream is
// idle, and words accepted after the write use the new matrix. Indexes 8 to
// 15 on the config port are ignored.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_4x4 import vt4_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [VEC_W-1:0] s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  logic             s_axis_tuser,  // func
  input  logic             s_axis_tlast,  // last_vector
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VEC_W-1:0] m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic             m_axis_tuser,  // clipped
  output logic             m_axis_tlast,  // batch_end
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic [REG_W-1:0] mat [NUM_REGS];
  comp_t            ent [NUM_ROWS][NUM_COLS];
  comp_t            vec [NUM_COLS];
  sum_t             sums [NUM_ROWS];
  vt4_ctl_t         ctl_s1;
  vt4_ctl_t         ctl_s2;
  logic             adv;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS))) begin
      mat[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // entry (r,c) lives in register 2r + c/2, half c%2
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        ent[r][c] = mat[2*r + c/2][(c%2)*DATA_W +: DATA_W];
      end
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      vec[c] = s_axis_tdata[c*DATA_W +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
      ctl_s2 <= '0;
    end else if (adv) begin
      ctl_s1 <= '{valid: s_axis_tvalid, func: s_axis_tuser, last: s_axis_tlast};
      ctl_s2 <= ctl_s1;
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    vt4_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .row  (ent[r]),
      .vec  (vec),
      .func (s_axis_tuser),
      .sum  (sums[r])
    );
  end

  vt4_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .sums          (sums),
    .in_ctl        (ctl_s2),
    .adv           (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
